### sv/assert_macros.svh
// assertion macros used by cyclic_convolution_mod_q_core, the rtl file that checks itself
// needs clk and arst_n in scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ccmq_pkg.sv
// shared constants, types and the centring function of the cyclic convolution core
// no dependencies
package ccmq_pkg;

	localparam int MAX_COEFFS = 512;
	localparam int COEF_W     = 16;
	localparam int IDX_W      = $clog2(MAX_COEFFS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COUNT_W    = 10;
	localparam int MLOG_W     = 4;
	localparam int ACC_W      = 1 << MLOG_W;
	localparam int MOD_W      = ACC_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COUNT_W;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(401);
	localparam logic [MLOG_W-1:0]  MLOG_RESET  = MLOG_W'(11);

	localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_LOG2 = 1'b1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_LOAD,
		OP_MAC,
		OP_UNLOAD
	} chain_op_t;

	typedef struct packed {
		chain_op_t        op;
		logic [IDX_W-1:0] cnt_addr;
		logic [IDX_W-1:0] a_addr;
		logic [IDX_W-1:0] wr_addr;
		logic             done;
	} seq_issue_t;

	// residue modulo 2^m mapped to (-q/2, q/2]
	function automatic logic [ACC_W-1:0] centre_mod(input logic [ACC_W-1:0] x,
			input logic [MLOG_W-1:0] m);
		logic [MOD_W-1:0] q;
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] half;
		q    = MOD_W'(1) << m;
		r    = MOD_W'(x) & (q - MOD_W'(1));
		half = q >> 1;
		if (r > half) begin
			r = r - q;
		end
		return r[ACC_W-1:0];
	endfunction

endpackage

### sv/ccmq_cell.sv
// one multiply-accumulate cell of the convolution chain
// depends on ccmq_pkg
module ccmq_cell (
	input  logic                     clk,
	input  ccmq_pkg::chain_op_t      op,
	input  logic [ccmq_pkg::ACC_W-1:0] a_bcast,
	input  logic [ccmq_pkg::ACC_W-1:0] b_in,
	input  logic [ccmq_pkg::ACC_W-1:0] acc_up_in,
	input  logic [ccmq_pkg::ACC_W-1:0] acc_dn_in,
	output logic [ccmq_pkg::ACC_W-1:0] b_out,
	output logic [ccmq_pkg::ACC_W-1:0] acc_out
);
	import ccmq_pkg::*;

	logic [ACC_W-1:0] b_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] prod;

	// only the low half of the product survives the power-of-two modulus
	assign prod = a_bcast * b_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				b_q   <= b_in;
				acc_q <= acc_up_in;
			end
			OP_MAC: begin
				b_q   <= b_in;
				acc_q <= acc_q + prod;
			end
			OP_UNLOAD: begin
				acc_q <= acc_dn_in;
			end
			default: begin
				b_q   <= b_q;
				acc_q <= acc_q;
			end
		endcase
	end

	assign b_out   = b_q;
	assign acc_out = acc_q;

endmodule

### sv/ccmq_seq.sv
// sequencer for the load, multiply-accumulate and unload passes of the chain
// depends on ccmq_pkg
module ccmq_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ccmq_pkg::CNT_W-1:0] ring,
	output ccmq_pkg::seq_issue_t     issue
);
	import ccmq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_MAC,
		S_UNLOAD
	} seq_state_t;

	seq_state_t       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             last_step;

	assign last_step = ({1'b0, cnt_q} == (ring - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q <= last_step ? '0 : cnt_q + IDX_W'(1);
					if (last_step) begin
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					cnt_q <= last_step ? '0 : cnt_q + IDX_W'(1);
					if (last_step) begin
						state_q <= S_UNLOAD;
					end
				end
				S_UNLOAD: begin
					cnt_q <= last_step ? '0 : cnt_q + IDX_W'(1);
					if (last_step) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_comb begin
		issue.cnt_addr = cnt_q;
		// a is broadcast in reverse cyclic order: a[0], a[n-1], ..., a[1]
		issue.a_addr   = (cnt_q == '0) ? '0 : IDX_W'(ring - {1'b0, cnt_q});
		// unloading from cell 0 yields the highest coefficient first
		issue.wr_addr  = IDX_W'(ring - CNT_W'(1) - {1'b0, cnt_q});
		issue.done     = (state_q == S_UNLOAD) && last_step;
		unique case (state_q)
			S_LOAD:   issue.op = OP_LOAD;
			S_MAC:    issue.op = OP_MAC;
			S_UNLOAD: issue.op = OP_UNLOAD;
			default:  issue.op = OP_IDLE;
		endcase
	end

endmodule

### sv/cyclic_convolution_mod_q_core.sv
// Cyclic convolution modulo x^n - 1 and q = 2^modulus_log2, built on ccmq_pkg, ccmq_seq and a
// row of MAX_COEFFS ccmq_cell multiply-accumulate cells. A load word writes a, b and the initial
// accumulator at its index; in-range loads can follow back to back. A read word passes through
// the registered read of the accumulator memory, and the input stalls until its result moves on
// to an output register, where it waits so the next word can still be accepted. The load marked
// last starts the convolution; with n the ring size, the block stalls its input through n steps
// that shift b and the accumulators into the cell row, n multiply-accumulate steps with one
// coefficient of a broadcast to all cells per cycle, and n to shift the centred results back
// into memory. Ring size zero starts nothing. Indices at or above n give a flagged zero result.
`include "assert_macros.svh"

module cyclic_convolution_mod_q_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ccmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccmq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [ccmq_pkg::IDX_W-1:0]      index,
	input  logic signed [15:0]            coef_a,
	input  logic signed [15:0]            coef_b,
	input  logic signed [15:0]            acc_in,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ccmq_pkg::IDX_W-1:0]      out_index,
	output logic signed [ccmq_pkg::ACC_W-1:0] out_coef,
	output logic                          out_of_range
);
	import ccmq_pkg::*;

	logic [COUNT_W-1:0] coeff_count_q;
	logic [MLOG_W-1:0]  modulus_log2_q;
	logic [CNT_W-1:0]   ring;

	logic in_acc, ld_acc, rd_acc, in_ring, start;
	logic busy_q;

	seq_issue_t       seq_issue;
	chain_op_t        op_s1;
	logic             done_s1;
	logic [IDX_W-1:0] wr_addr_s1;

	logic [COEF_W-1:0] poly_a_mem [MAX_COEFFS];
	logic [COEF_W-1:0] poly_b_mem [MAX_COEFFS];
	logic [ACC_W-1:0]  accum_mem  [MAX_COEFFS];
	logic [COEF_W-1:0] a_rd_q;
	logic [COEF_W-1:0] b_rd_q;
	logic [ACC_W-1:0]  acc_rd_q;
	logic [ACC_W-1:0]  a_ext;
	logic [ACC_W-1:0]  b_ext;

	logic [ACC_W-1:0] b_chain   [MAX_COEFFS];
	logic [ACC_W-1:0] acc_chain [MAX_COEFFS];

	logic             s1_valid_q;
	logic             s1_oor_q;
	logic [IDX_W-1:0] s1_index_q;
	logic             out_move;
	logic             out_valid_q;
	logic             out_oor_q;
	logic [IDX_W-1:0] out_index_q;
	logic [ACC_W-1:0] out_coef_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_count_q  <= COUNT_RESET;
			modulus_log2_q <= MLOG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEFF_COUNT:  coeff_count_q  <= cfg_wdata[COUNT_W-1:0];
				REG_MODULUS_LOG2: modulus_log2_q <= cfg_wdata[MLOG_W-1:0];
				default: begin
					coeff_count_q  <= coeff_count_q;
					modulus_log2_q <= modulus_log2_q;
				end
			endcase
		end
	end

	assign ring = (coeff_count_q > COUNT_W'(MAX_COEFFS)) ? CNT_W'(MAX_COEFFS)
		: CNT_W'(coeff_count_q);

	// input word handling
	assign in_stall = busy_q | s1_valid_q;
	assign in_acc   = in_valid & ~in_stall;
	assign ld_acc   = in_acc && (func == FUNC_LOAD);
	assign rd_acc   = in_acc && (func == FUNC_READ);
	assign in_ring  = ({1'b0, index} < ring);
	assign start    = ld_acc && last && (ring != '0);

	ccmq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ring   (ring),
		.issue  (seq_issue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			op_s1   <= OP_IDLE;
			done_s1 <= 1'b0;
		end else begin
			op_s1   <= seq_issue.op;
			done_s1 <= seq_issue.done;
			if (start) begin
				busy_q <= 1'b1;
			end else if (done_s1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= seq_issue.wr_addr;
	end

	// coefficient memories
	always_ff @(posedge clk) begin
		if (ld_acc && in_ring) begin
			poly_a_mem[index] <= coef_a[COEF_W-1:0];
			poly_b_mem[index] <= coef_b[COEF_W-1:0];
		end
		a_rd_q <= poly_a_mem[seq_issue.a_addr];
		b_rd_q <= poly_b_mem[seq_issue.cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (op_s1 == OP_UNLOAD) begin
			accum_mem[wr_addr_s1] <= centre_mod(acc_chain[0], modulus_log2_q);
		end else if (ld_acc && in_ring) begin
			accum_mem[index] <= ACC_W'($signed(acc_in[COEF_W-1:0]));
		end
		if (seq_issue.op == OP_LOAD) begin
			acc_rd_q <= accum_mem[seq_issue.cnt_addr];
		end else if (rd_acc) begin
			acc_rd_q <= accum_mem[index];
		end
	end

	assign a_ext = ACC_W'($signed(a_rd_q));
	assign b_ext = ACC_W'($signed(b_rd_q));

	// cell row: b and accumulators enter at cell 0, results leave through cell 0
	for (genvar p = 0; p < MAX_COEFFS; p++) begin : g_cell
		logic [ACC_W-1:0] b_left;
		logic [ACC_W-1:0] acc_left;
		logic [ACC_W-1:0] acc_right;

		if (p == 0) begin : g_head
			assign b_left   = b_ext;
			assign acc_left = acc_rd_q;
		end else begin : g_body
			assign b_left   = b_chain[p-1];
			assign acc_left = acc_chain[p-1];
		end

		if (p == MAX_COEFFS - 1) begin : g_tail
			assign acc_right = '0;
		end else begin : g_inner
			assign acc_right = acc_chain[p+1];
		end

		ccmq_cell u_cell (
			.clk       (clk),
			.op        (op_s1),
			.a_bcast   (a_ext),
			.b_in      (b_left),
			.acc_up_in (acc_left),
			.acc_dn_in (acc_right),
			.b_out     (b_chain[p]),
			.acc_out   (acc_chain[p])
		);
	end

	// result path: one word waits for memory data, one sits in the output register
	assign out_move = s1_valid_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_acc || (ld_acc && !in_ring)) begin
				s1_valid_q <= 1'b1;
			end else if (out_move) begin
				s1_valid_q <= 1'b0;
			end
			if (out_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_index_q <= index;
			s1_oor_q   <= !in_ring;
		end
		if (out_move) begin
			out_index_q <= s1_index_q;
			out_oor_q   <= s1_oor_q;
			out_coef_q  <= s1_oor_q ? '0 : centre_mod(acc_rd_q, modulus_log2_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_index    = out_index_q;
	assign out_coef     = out_coef_q;
	assign out_of_range = out_oor_q;

	`ASSERT_IMPL(a_seq_within_busy, seq_issue.op != OP_IDLE, busy_q,
		"sequencer running while block not busy")
	`ASSERT_IMPL(a_read_no_overlap, s1_valid_q && !s1_oor_q, seq_issue.op == OP_IDLE,
		"read word waiting while accumulator memory port is in use")
	`ASSERT_NEXT(a_start_loads, start, seq_issue.op == OP_LOAD,
		"convolution start not followed by load pass")

endmodule

### bench/tb_cyclic_convolution_mod_q_core.sv
// testbench for cyclic_convolution_mod_q_core: directed table, then random load/convolve/read
// sequences; results checked in order against the table or a model. needs ccmq_pkg and the core
module tb_cyclic_convolution_mod_q_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ccmq_pkg::*;

	localparam int RANDOM_WORDS = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 20000;
	localparam int N_ROWS       = 33;

	typedef struct packed {
		logic [IDX_W-1:0] pos;
		logic [ACC_W-1:0] coef;
		logic             flag;
	} coef_result_t;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_COUNT,
		ROW_MLOG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             f;
		logic [9:0]       arg;
		logic [15:0]      a;
		logic [15:0]      b;
		logic [15:0]      acc;
		logic             lst;
		logic             pin;
		logic [15:0]      pin_coef;
		logic             pin_oor;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic                    func      = FUNC_LOAD;
	logic [IDX_W-1:0]        index     = '0;
	logic signed [15:0]      coef_a    = '0;
	logic signed [15:0]      coef_b    = '0;
	logic signed [15:0]      acc_in    = '0;
	logic                    last      = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [IDX_W-1:0]        out_index;
	logic signed [ACC_W-1:0] out_coef;
	logic                    out_of_range;

	// expectation typed into the table travels with the word
	logic                    tag_pinned = 1'b0;
	logic [ACC_W-1:0]        tag_coef   = '0;
	logic                    tag_oor    = 1'b0;

	// local copy of the block's state
	logic [31:0]             a_mem   [MAX_COEFFS];
	logic [31:0]             b_mem   [MAX_COEFFS];
	logic [31:0]             acc_mem [MAX_COEFFS];
	logic [COUNT_W-1:0]      count_reg = COUNT_RESET;
	logic [MLOG_W-1:0]       mlog_reg  = MLOG_RESET;

	coef_result_t            coef_expect [$];
	int                      mismatches    = 0;
	int                      words_sent    = 0;
	bit                      gen_loaded [MAX_COEFFS];
	bit                      calm          = 1'b0;
	int                      hold_off_req  = 0;
	int                      hold_offs_done = 0;
	stim_row_t               directed_rows [N_ROWS];

	cyclic_convolution_mod_q_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.index        (index),
		.coef_a       (coef_a),
		.coef_b       (coef_b),
		.acc_in       (acc_in),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_index    (out_index),
		.out_coef     (out_coef),
		.out_of_range (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned ring_len();
		return (count_reg > COUNT_W'(MAX_COEFFS)) ? MAX_COEFFS : int'(count_reg);
	endfunction

	// residue modulo 2^mlog in (-q/2, q/2]
	function automatic logic [ACC_W-1:0] centre_q(logic [31:0] x);
		logic [31:0] q;
		logic [31:0] r;
		q = 32'd1 << mlog_reg;
		r = x & (q - 32'd1);
		if (r > (q >> 1)) begin
			r = r - q;
		end
		return r[ACC_W-1:0];
	endfunction

	task automatic convolve_model();
		logic [31:0] sum [MAX_COEFFS];
		logic [ACC_W-1:0] c;
		int unsigned n;
		int unsigned k;
		n = ring_len();
		for (int unsigned i = 0; i < n; i++) begin
			sum[i] = acc_mem[i];
		end
		for (int unsigned i = 0; i < n; i++) begin
			for (int unsigned j = 0; j < n; j++) begin
				k = i + j;
				if (k >= n) begin
					k = k - n;
				end
				sum[k] = sum[k] + a_mem[j] * b_mem[i];
			end
		end
		for (int unsigned i = 0; i < n; i++) begin
			c = centre_q(sum[i]);
			acc_mem[i] = {{(32 - ACC_W){c[ACC_W-1]}}, c};
		end
	endtask

	task automatic predict_word(input logic f, input logic [IDX_W-1:0] ix,
			input logic [15:0] ca, input logic [15:0] cb, input logic [15:0] ac,
			input logic lst, output logic produced, output coef_result_t res);
		logic hit;
		hit = ix < ring_len();
		produced = 1'b0;
		res = '0;
		res.pos = ix;
		if (f == FUNC_LOAD) begin
			if (hit) begin
				a_mem[ix]   = {{16{ca[15]}}, ca};
				b_mem[ix]   = {{16{cb[15]}}, cb};
				acc_mem[ix] = {{16{ac[15]}}, ac};
			end
			if (lst) begin
				convolve_model();
			end
			if (!hit) begin
				produced = 1'b1;
				res.flag = 1'b1;
			end
		end else begin
			produced = 1'b1;
			if (hit) begin
				res.coef = centre_q(acc_mem[ix]);
			end else begin
				res.flag = 1'b1;
			end
		end
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
		end
	endtask

	always @(posedge clk) begin : watch_ports
		coef_result_t want;
		coef_result_t pred;
		logic produced;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_COEFF_COUNT) begin
					count_reg = cfg_wdata[COUNT_W-1:0];
				end else if (cfg_index == REG_MODULUS_LOG2) begin
					mlog_reg = cfg_wdata[MLOG_W-1:0];
				end
			end
			if (out_valid && !out_stall) begin
				if (coef_expect.size() == 0) begin
					flag_mismatch("unexpected result, index", int'(out_index), -1);
				end else begin
					want = coef_expect.pop_front();
					if (out_index != want.pos) begin
						flag_mismatch("out_index", int'(out_index), int'(want.pos));
					end
					if (out_coef != want.coef) begin
						flag_mismatch($sformatf("out_coef at %0d", want.pos),
							int'(out_coef), int'($signed(want.coef)));
					end
					if (out_of_range != want.flag) begin
						flag_mismatch($sformatf("out_of_range at %0d", want.pos),
							int'(out_of_range), int'(want.flag));
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_word(func, index, coef_a, coef_b, acc_in, last, produced, pred);
				if (produced) begin
					if (tag_pinned) begin
						pred.coef = tag_coef;
						pred.flag = tag_oor;
					end
					coef_expect.push_back(pred);
				end
			end
		end
	end

	// receiver: random stalls, and on request one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_offs_done != hold_off_req) begin
				hold_offs_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 35);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 7))
			4: return 16'($urandom_range(0, 8)) - 16'd4;
			5: return 16'd0;
			6: return 16'h8000;
			7: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic offer(logic f, logic [IDX_W-1:0] ix, logic [15:0] ca, logic [15:0] cb,
			logic [15:0] ac, logic lst, logic pin, logic [ACC_W-1:0] pin_coef,
			logic pin_oor);
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		index      <= ix;
		coef_a     <= ca;
		coef_b     <= cb;
		acc_in     <= ac;
		last       <= lst;
		tag_pinned <= pin;
		tag_coef   <= pin_coef;
		tag_oor    <= pin_oor;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f == FUNC_LOAD && ix < ring_len()) begin
			gen_loaded[ix] = 1'b1;
		end
		words_sent++;
	endtask

	task automatic offer_free(logic f, int ix, logic lst);
		offer(f, IDX_W'(ix), rand_coef(), rand_coef(), rand_coef(), lst, 1'b0, '0, 1'b0);
	endtask

	// drain, then let a convolution that gave no word run out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (coef_expect.size() != 0) @(posedge clk);
		repeat (3 * ring_len() + 24) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit ready_to_run(int unsigned n, int extra);
		for (int unsigned i = 0; i < n; i++) begin
			if (!gen_loaded[i] && int'(i) != extra) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// full load of the ring in random order, last on the final word, then read back
	task automatic well_formed(int unsigned n, bit squeeze);
		int order [$];
		int pick;
		int tmp;
		int unsigned reads;
		for (int unsigned k = 0; k < n; k++) begin
			order.push_back(int'(k));
		end
		for (int k = int'(n) - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[pick];
			order[pick] = tmp;
		end
		for (int unsigned k = 0; k < n; k++) begin
			if (n < MAX_COEFFS && $urandom_range(0, 9) == 0) begin
				offer_free(1'($urandom_range(0, 1)), $urandom_range(n, MAX_COEFFS - 1), 1'b0);
			end
			offer_free(FUNC_LOAD, order[k], k == n - 1);
		end
		reads = (n <= 64) ? n : 48;
		for (int unsigned k = 0; k < reads; k++) begin
			offer_free(FUNC_READ, (n <= 64) ? order[k] : $urandom_range(0, n - 1),
				1'($urandom_range(0, 1)));
			// hold the receiver once the run is over and reads are flowing
			if (squeeze && k == 0) begin
				hold_off_req++;
			end
		end
		if (n < MAX_COEFFS) begin
			offer_free(FUNC_READ, $urandom_range(n, MAX_COEFFS - 1), 1'b0);
		end
	endtask

	// loose words: stray reads, stray loads, runs started from whatever is loaded
	task automatic noise(int unsigned n, int unsigned count);
		logic f;
		logic lst;
		int ix;
		repeat (count) begin
			f = 1'($urandom_range(0, 1));
			if (n != 0 && $urandom_range(0, 1) == 1) begin
				ix = $urandom_range(0, n - 1);
			end else begin
				ix = $urandom_range(0, MAX_COEFFS - 1);
			end
			if (f == FUNC_READ && ix < int'(n) && !gen_loaded[ix]) begin
				f = FUNC_LOAD;
			end
			lst = ($urandom_range(0, 7) == 0);
			if (f == FUNC_LOAD && lst && !ready_to_run(n, ix)) begin
				lst = 1'b0;
			end
			offer_free(f, ix, lst);
		end
	endtask

	initial begin
		int unsigned r;
		int unsigned cnt;
		int unsigned n;
		int phase;
		int wf;
		int random_start;
		stim_row_t row;

		directed_rows = '{
			'{ROW_WORD, FUNC_READ, 10'd511, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1},
			'{ROW_WORD, FUNC_LOAD, 10'd450, 16'd1, 16'd1, 16'd1, 1'b0, 1'b1, 16'd0, 1'b1},
			'{ROW_WORD, FUNC_LOAD, 10'd0, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'd0, 1'b0},
			// most negative accumulator is a multiple of q
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_LOAD, 10'd1, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
			'{ROW_COUNT, FUNC_LOAD, 10'd2, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_MLOG, FUNC_LOAD, 10'd15, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_LOAD, 10'd1, 16'hFFFF, 16'd2, 16'd100, 1'b1, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd2, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1},
			// q of one clears every coefficient
			'{ROW_MLOG, FUNC_LOAD, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0},
			// empty ring: all out of range, last starts nothing
			'{ROW_COUNT, FUNC_LOAD, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1},
			'{ROW_WORD, FUNC_LOAD, 10'd0, 16'd5, 16'd5, 16'd5, 1'b1, 1'b1, 16'd0, 1'b1},
			'{ROW_COUNT, FUNC_LOAD, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_MLOG, FUNC_LOAD, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_LOAD, 10'd0, 16'd3, 16'd5, 16'd1, 1'b1, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 1'b1},
			// ring size beyond the store saturates
			'{ROW_COUNT, FUNC_LOAD, 10'd1023, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_MLOG, FUNC_LOAD, 10'd15, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_LOAD, 10'd511, 16'hFFF9, 16'd9, 16'hFFFD, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd511, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'hFFFD, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_COUNT, FUNC_LOAD, 10'd3, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_MLOG, FUNC_LOAD, 10'd8, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_LOAD, 10'd2, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0},
			'{ROW_WORD, FUNC_READ, 10'd2, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0}
		};
		for (int i = 0; i < MAX_COEFFS; i++) begin
			gen_loaded[i] = 1'b0;
			a_mem[i]      = '0;
			b_mem[i]      = '0;
			acc_mem[i]    = '0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_WORD: begin
					offer(row.f, row.arg[IDX_W-1:0], row.a, row.b, row.acc, row.lst,
						row.pin, row.pin_coef, row.pin_oor);
				end
				ROW_COUNT: begin
					settle();
					write_reg(REG_COEFF_COUNT, CFG_DATA_W'(row.arg));
				end
				default: begin
					settle();
					write_reg(REG_MODULUS_LOG2, CFG_DATA_W'(row.arg));
				end
			endcase
		end

		phase = 0;
		wf = 0;
		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			phase++;
			settle();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				cnt = $urandom_range(1, 10);
			end else if (r < 70) begin
				cnt = 2;
			end else if (r < 82) begin
				cnt = $urandom_range(11, 96);
			end else if (r < 88) begin
				cnt = 0;
			end else if (r < 94) begin
				cnt = $urandom_range(513, 1023);
			end else begin
				cnt = MAX_COEFFS;
			end
			write_reg(REG_COEFF_COUNT, CFG_DATA_W'(cnt));
			// upper data bits are don't-care for the modulus register
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_MODULUS_LOG2, CFG_DATA_W'($urandom_range(0, 1023)));
			end
			calm = (phase >= 6 && phase <= 12);
			n = ring_len();
			if (n >= 1 && n <= 96 && $urandom_range(0, 99) < 80) begin
				wf++;
				well_formed(n, wf == 2 || wf == 9);
			end else begin
				noise(n, $urandom_range(6, 30));
			end
		end

		// one run at full ring size, no idling, receiver held once during the read-back
		settle();
		calm = 1'b1;
		write_reg(REG_COEFF_COUNT, CFG_DATA_W'(MAX_COEFFS));
		write_reg(REG_MODULUS_LOG2, CFG_DATA_W'($urandom_range(1, 15)));
		well_formed(MAX_COEFFS, 1'b1);

		settle();
		if (mismatches == 0 && coef_expect.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/ccmq_pkg.sv
sv/ccmq_cell.sv
sv/ccmq_seq.sv
sv/cyclic_convolution_mod_q_core.sv
bench/tb_cyclic_convolution_mod_q_core.sv
